FILE: sv/sgf_pkg.sv
package sgf_pkg;

	// fixed widths and scaling
	localparam int DIST_BITS      = 13;
	localparam int ANGLE_BITS     = 8;
	localparam int MAX_ANGLE      = 180;
	localparam int SINE_FRAC_BITS = 15;
	localparam int WIDTH_BITS     = 14;
	localparam int CENTER_BITS    = ANGLE_BITS + 1;
	localparam int TURN_BITS      = 9;
	localparam int SINE_DEPTH     = 1 << ANGLE_BITS;
	localparam int ADDR_BITS      = 4;
	localparam int DATA_BITS      = 32;

	localparam logic [WIDTH_BITS-1:0] WIDTH_MAX   = '1;
	localparam logic [WIDTH_BITS-1:0] MIN_WIDTH_RST = WIDTH_BITS'(280);
	localparam logic [63:0]           PI_Q30      = 64'd3373259426;

	// register indexes
	typedef enum logic [1:0] {
		REG_MIN_DIST_HOLE,
		REG_DEFAULT_DIST,
		REG_MIN_WIDTH
	} reg_idx_t;

	// payload of one sample transfer
	typedef struct packed {
		logic [ANGLE_BITS-1:0] scan_angle;
		logic [DIST_BITS-1:0]  range_dist;
		logic                  sweep_reverse;
	} sample_t;

	// payload of one result transfer
	typedef struct packed {
		logic signed [TURN_BITS-1:0] best_turn_half_deg;
		logic [CENTER_BITS-1:0]      last_center_half_deg;
		logic                        hole_found;
	} result_t;

	// request to the width unit
	typedef struct packed {
		logic [ANGLE_BITS-1:0] span;
		logic [DIST_BITS-1:0]  dmin;
	} width_req_t;

	typedef logic [SINE_FRAC_BITS:0] sine_t;
	typedef sine_t [SINE_DEPTH-1:0]  sine_rom_t;

	// sin(h half degrees) in Q1.SINE_FRAC_BITS, odd series in Q30 through x^13
	function automatic sine_t sine_entry(input int unsigned h_in);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		int unsigned h;
		h = h_in % SINE_DEPTH;
		if (h > 180) begin
			h = 360 - h;
		end
		x  = (64'(h) * PI_Q30) / 64'd360;
		x2 = (x * x) >> 30;
		t  = x;
		s  = x;
		t  = ((t * x2) >> 30) / 64'd6;
		s  = s - t;
		t  = ((t * x2) >> 30) / 64'd20;
		s  = s + t;
		t  = ((t * x2) >> 30) / 64'd42;
		s  = s - t;
		t  = ((t * x2) >> 30) / 64'd72;
		s  = s + t;
		t  = ((t * x2) >> 30) / 64'd110;
		s  = s - t;
		t  = ((t * x2) >> 30) / 64'd156;
		s  = s + t;
		return sine_t'((s + (64'd1 << (29 - SINE_FRAC_BITS))) >> (30 - SINE_FRAC_BITS));
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			rom[i] = sine_entry(i);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: sv/sgf_width_calc.sv
module sgf_width_calc
	import sgf_pkg::*;
(
	input  width_req_t            req,
	output logic [WIDTH_BITS-1:0] gap_width
);

	localparam int PROD_BITS = DIST_BITS + SINE_FRAC_BITS + 1;
	localparam int SUM_BITS  = PROD_BITS + 2;
	localparam int WIDE_BITS = SUM_BITS - SINE_FRAC_BITS;

	sine_t                  sine;
	logic [PROD_BITS-1:0]   prod;
	logic [SUM_BITS-1:0]    sum;
	logic [WIDE_BITS-1:0]   wide;

	// sine of half the span, then 2*dmin*sine rounded back to integer units, saturated to WIDTH_MAX
	always_comb begin
		sine = SINE_ROM[req.span];
		prod = PROD_BITS'(req.dmin) * PROD_BITS'(sine);
		sum  = {1'b0, prod, 1'b0} + (SUM_BITS'(1) << (SINE_FRAC_BITS - 1));
		wide = sum[SUM_BITS-1:SINE_FRAC_BITS];
		if (wide > WIDE_BITS'(WIDTH_MAX)) begin
			gap_width = WIDTH_MAX;
		end else begin
			gap_width = wide[WIDTH_BITS-1:0];
		end
	end

endmodule

FILE: sv/scan_gap_finder_unit.sv
// channel   | signals                                  | moves
// ----------+------------------------------------------+------------------------------
// sample    | sample_valid, sample_ready, sample       | one scan sample per transfer
// result    | result_valid, result_ready, result       | one result per sample
// config    | psel, penable, pwrite, paddr, pwdata,    | registers at 0x0, 0x4, 0x8
//           | prdata, pready                           | pready tied high
//
// a sample is held in the input register, then evaluated combinationally (sine rom,
// one 13x16 multiply, compare) as it moves into the result register
// sustained rate one sample per cycle while the result side is not stalled
// a stalled result holds the result register; once the input register holds a
// sample, sample_ready drops until the result transfer completes
// arst_n clears all gap state and sets the registers to their reset values
module scan_gap_finder_unit
	import sgf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  sample_t              sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);

	localparam int TW_BITS = ANGLE_BITS + 2;
	localparam logic signed [TW_BITS-1:0] TURN_HI = TW_BITS'((1 << (TURN_BITS - 1)) - 1);
	localparam logic signed [TW_BITS-1:0] TURN_LO = -TW_BITS'(1 << (TURN_BITS - 1));

	// configuration registers
	logic [DIST_BITS-1:0]  min_dist_hole_q;
	logic [DIST_BITS-1:0]  default_dist_q;
	logic [WIDTH_BITS-1:0] min_width_q;
	reg_idx_t              reg_idx;
	logic                  cfg_wr;

	// gap state
	logic                        inside_q;
	logic [DIST_BITS-1:0]        prev_dist_q;
	logic [ANGLE_BITS-1:0]       prev_angle_q;
	logic [DIST_BITS-1:0]        start_dist_q;
	logic [ANGLE_BITS-1:0]       start_angle_q;
	logic [CENTER_BITS-1:0]      last_center_q;
	logic signed [TURN_BITS-1:0] best_turn_q;
	logic [WIDTH_BITS-1:0]       best_width_q;
	logic                        first_found_q;
	logic                        found_q;

	// next state
	logic                        inside_nxt;
	logic [DIST_BITS-1:0]        start_dist_nxt;
	logic [ANGLE_BITS-1:0]       start_angle_nxt;
	logic [CENTER_BITS-1:0]      last_center_nxt;
	logic signed [TURN_BITS-1:0] best_turn_nxt;
	logic [WIDTH_BITS-1:0]       best_width_nxt;
	logic                        first_found_nxt;
	logic                        found_nxt;

	// pipeline
	sample_t smp_s1;
	logic    valid_s1;
	logic    adv;
	result_t res_q;
	logic    res_valid_q;

	// evaluation
	logic                        close_gap;
	logic                        open_gap;
	logic                        take_best;
	logic [DIST_BITS-1:0]        end_dist;
	logic [CENTER_BITS-1:0]      center;
	logic signed [TW_BITS-1:0]   turn_wide;
	logic signed [TURN_BITS-1:0] turn;
	width_req_t                  wreq;
	logic [WIDTH_BITS-1:0]       gap_width;

	// config port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_hole_q <= '0;
			default_dist_q  <= '0;
			min_width_q     <= MIN_WIDTH_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_MIN_DIST_HOLE: min_dist_hole_q <= pwdata[DIST_BITS-1:0];
				REG_DEFAULT_DIST:  default_dist_q  <= pwdata[DIST_BITS-1:0];
				REG_MIN_WIDTH:     min_width_q     <= pwdata[WIDTH_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MIN_DIST_HOLE: prdata = DATA_BITS'(min_dist_hole_q);
			REG_DEFAULT_DIST:  prdata = DATA_BITS'(default_dist_q);
			REG_MIN_WIDTH:     prdata = DATA_BITS'(min_width_q);
			default:           prdata = '0;
		endcase
	end

	// handshake: input register feeds result register
	assign adv          = valid_s1 && (!res_valid_q || result_ready);
	assign sample_ready = !valid_s1 || adv;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			smp_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.best_turn_half_deg   <= best_turn_nxt;
			res_q.last_center_half_deg <= last_center_nxt;
			res_q.hole_found           <= found_nxt;
		end
	end

	// gap geometry of the sample in the input register
	always_comb begin
		close_gap = inside_q && (smp_s1.range_dist <= min_dist_hole_q || smp_s1.sweep_reverse);
		open_gap  = !inside_q && (smp_s1.range_dist > min_dist_hole_q);
		end_dist  = smp_s1.sweep_reverse ? default_dist_q : smp_s1.range_dist;
		if (start_angle_q > smp_s1.scan_angle) begin
			wreq.span = start_angle_q - smp_s1.scan_angle;
		end else begin
			wreq.span = smp_s1.scan_angle - start_angle_q;
		end
		wreq.dmin = (start_dist_q < end_dist) ? start_dist_q : end_dist;
		center    = CENTER_BITS'(start_angle_q) + CENTER_BITS'(smp_s1.scan_angle);
		turn_wide = $signed(TW_BITS'(center)) - TW_BITS'(MAX_ANGLE);
		if (turn_wide > TURN_HI) begin
			turn = TURN_HI[TURN_BITS-1:0];
		end else if (turn_wide < TURN_LO) begin
			turn = TURN_LO[TURN_BITS-1:0];
		end else begin
			turn = turn_wide[TURN_BITS-1:0];
		end
	end

	sgf_width_calc u_width (
		.req       (wreq),
		.gap_width (gap_width)
	);

	// next gap state
	always_comb begin
		take_best       = close_gap && (gap_width >= min_width_q) &&
			(gap_width > best_width_q || !first_found_q);
		inside_nxt      = inside_q;
		start_dist_nxt  = start_dist_q;
		start_angle_nxt = start_angle_q;
		last_center_nxt = last_center_q;
		best_turn_nxt   = best_turn_q;
		best_width_nxt  = best_width_q;
		first_found_nxt = first_found_q;
		found_nxt       = found_q;
		if (close_gap) begin
			last_center_nxt = center;
			inside_nxt      = 1'b0;
			if (take_best) begin
				best_turn_nxt   = turn;
				best_width_nxt  = gap_width;
				first_found_nxt = 1'b1;
				found_nxt       = 1'b1;
			end
		end else if (open_gap) begin
			start_dist_nxt  = prev_dist_q;
			start_angle_nxt = prev_angle_q;
			inside_nxt      = 1'b1;
		end
		// sweep reversal: drop the best when nothing was found this sweep
		if (smp_s1.sweep_reverse) begin
			if (!first_found_nxt) begin
				best_turn_nxt  = '0;
				best_width_nxt = '0;
				found_nxt      = 1'b0;
			end
			first_found_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q      <= 1'b0;
			prev_dist_q   <= '0;
			prev_angle_q  <= '0;
			start_dist_q  <= '0;
			start_angle_q <= '0;
			last_center_q <= '0;
			best_turn_q   <= '0;
			best_width_q  <= '0;
			first_found_q <= 1'b0;
			found_q       <= 1'b0;
		end else if (adv) begin
			inside_q      <= inside_nxt;
			prev_dist_q   <= smp_s1.range_dist;
			prev_angle_q  <= smp_s1.scan_angle;
			start_dist_q  <= start_dist_nxt;
			start_angle_q <= start_angle_nxt;
			last_center_q <= last_center_nxt;
			best_turn_q   <= best_turn_nxt;
			best_width_q  <= best_width_nxt;
			first_found_q <= first_found_nxt;
			found_q       <= found_nxt;
		end
	end

	// checks
	a_no_best_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!found_q |-> (best_turn_q == '0 && best_width_q == '0))
		else $error("best gap held without hole flag");

	a_first_implies_found: assert property (@(posedge clk) disable iff (!arst_n)
		first_found_q |-> found_q)
		else $error("first gap flag set without hole flag");

	a_adv_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_valid_q)
		else $error("evaluated sample did not reach result register");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (valid_s1 && res_valid_q && !result_ready))
		else $error("input stalled with room downstream");

endmodule

FILE: dv/testbench.sv
module testbench;
	import sgf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF        = 4;
	localparam int RESET_CYCLES    = 10;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_PAD       = 4;
	localparam int LONG_HOLD       = 300;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 85;
	localparam int REPORT_LIMIT    = 10;
	localparam int PRESSURE_PHASE  = 3;

	localparam logic [ADDR_BITS-1:0] UNUSED_REG_ADDR = ADDR_BITS'(12);

	typedef enum logic {ROW_SCAN, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		sample_t               scan;
		logic                  known;
		result_t               known_res;
		logic [ADDR_BITS-1:0]  addr;
		logic [DATA_BITS-1:0]  wdata;
	} directed_row_t;

	// ports
	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_ready;
	sample_t              sample       = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;
	logic                 psel         = 1'b0;
	logic                 penable      = 1'b0;
	logic                 pwrite       = 1'b0;
	logic [ADDR_BITS-1:0] paddr        = '0;
	logic [DATA_BITS-1:0] pwdata       = '0;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	// register copies
	logic [DIST_BITS-1:0]  cfg_hole      = '0;
	logic [DIST_BITS-1:0]  cfg_default   = '0;
	logic [WIDTH_BITS-1:0] cfg_min_width = MIN_WIDTH_RST;

	// gap tracking state of the predictor
	logic                        in_gap            = 1'b0;
	logic [DIST_BITS-1:0]        prev_range        = '0;
	logic [ANGLE_BITS-1:0]       prev_bearing      = '0;
	logic [DIST_BITS-1:0]        gap_start_range   = '0;
	logic [ANGLE_BITS-1:0]       gap_start_bearing = '0;
	logic [CENTER_BITS-1:0]      closed_centre     = '0;
	logic signed [TURN_BITS-1:0] best_turn         = '0;
	logic [WIDTH_BITS-1:0]       best_width        = '0;
	logic                        sweep_has_best    = 1'b0;
	logic                        have_best         = 1'b0;

	logic [SINE_FRAC_BITS:0] sine_by_half_deg [SINE_DEPTH];

	result_t       steer_results_due [$];
	result_t       oldest_due;
	directed_row_t directed_rows [$];
	int            mismatch_count = 0;

	// traffic shaping
	bit sender_idles   = 1'b1;
	bit receiver_idles = 1'b1;
	bit hold_results   = 1'b0;

	// random sweep generator state
	int unsigned sweep_angle = 0;
	bit          sweep_up    = 1'b1;
	bit          sweep_open  = 1'b0;

	scan_gap_finder_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #CLK_HALF clk = ~clk;

	// sine of h half degrees, q1.15, odd series in q30 with truncating steps
	function automatic logic [SINE_FRAC_BITS:0] half_deg_sine(input int unsigned h);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		x    = (64'(h) * PI_Q30) / 64'd360;
		x2   = (x * x) >> 30;
		term = x;
		acc  = x;
		for (int n = 1; n < 13; n += 2) begin
			term = ((term * x2) >> 30) / 64'((n + 1) * (n + 2));
			if (((n >> 1) & 1) == 0) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		return (SINE_FRAC_BITS + 1)'((acc + (64'd1 << (29 - SINE_FRAC_BITS)))
			>> (30 - SINE_FRAC_BITS));
	endfunction

	// table folded about 90 degrees
	initial begin
		for (int h = 0; h < SINE_DEPTH; h++) begin
			sine_by_half_deg[h] = half_deg_sine((h > 180) ? 360 - h : h);
		end
	end

	// one sample through the gap tracker, returns the steering result
	function automatic result_t predict_steer(input sample_t s);
		logic [DIST_BITS-1:0] end_range;
		logic [DIST_BITS-1:0] near_range;
		logic [63:0]          gap_width;
		int                   span;
		int                   turn;
		result_t              r;
		if (in_gap && (s.range_dist <= cfg_hole || s.sweep_reverse)) begin
			// close the gap, a reversal ends it at the default distance
			end_range  = s.sweep_reverse ? cfg_default : s.range_dist;
			span       = (gap_start_bearing > s.scan_angle) ?
				int'(gap_start_bearing) - int'(s.scan_angle) :
				int'(s.scan_angle) - int'(gap_start_bearing);
			near_range = (gap_start_range < end_range) ? gap_start_range : end_range;
			closed_centre = CENTER_BITS'(int'(gap_start_bearing) + int'(s.scan_angle));
			turn = int'(closed_centre) - MAX_ANGLE;
			if (turn > 255) begin
				turn = 255;
			end
			if (turn < -256) begin
				turn = -256;
			end
			gap_width = (64'd2 * near_range * sine_by_half_deg[span]
				+ (64'd1 << (SINE_FRAC_BITS - 1))) >> SINE_FRAC_BITS;
			if (gap_width > WIDTH_MAX) begin
				gap_width = WIDTH_MAX;
			end
			if (gap_width >= cfg_min_width && (gap_width > best_width || !sweep_has_best)) begin
				best_turn      = TURN_BITS'(turn);
				best_width     = WIDTH_BITS'(gap_width);
				sweep_has_best = 1'b1;
				have_best      = 1'b1;
			end
			in_gap = 1'b0;
		end else if (!in_gap && s.range_dist > cfg_hole) begin
			// open at the previous sample
			gap_start_range   = prev_range;
			gap_start_bearing = prev_bearing;
			in_gap            = 1'b1;
		end
		prev_range   = s.range_dist;
		prev_bearing = s.scan_angle;
		// a sweep with no usable gap drops the best one
		if (s.sweep_reverse) begin
			if (!sweep_has_best) begin
				best_turn  = '0;
				best_width = '0;
				have_best  = 1'b0;
			end
			sweep_has_best = 1'b0;
		end
		r.best_turn_half_deg   = best_turn;
		r.last_center_half_deg = closed_centre;
		r.hole_found           = have_best;
		return r;
	endfunction

	function automatic logic [ADDR_BITS-1:0] reg_addr(input reg_idx_t idx);
		return ADDR_BITS'({idx, 2'b00});
	endfunction

	// value in the low bits, noise above the register width
	function automatic logic [DATA_BITS-1:0] with_junk(input int unsigned v, input int w);
		return DATA_BITS'(v) | (DATA_BITS'($urandom()) << w);
	endfunction

	function automatic directed_row_t scan_row(input int a, input int d, input bit rev);
		directed_row_t row;
		row                    = '0;
		row.kind               = ROW_SCAN;
		row.scan.scan_angle    = ANGLE_BITS'(a);
		row.scan.range_dist    = DIST_BITS'(d);
		row.scan.sweep_reverse = rev;
		return row;
	endfunction

	function automatic directed_row_t known_row(input int a, input int d, input bit rev,
			input int turn, input int centre, input bit found);
		directed_row_t row;
		row                                = scan_row(a, d, rev);
		row.known                          = 1'b1;
		row.known_res.best_turn_half_deg   = TURN_BITS'(turn);
		row.known_res.last_center_half_deg = CENTER_BITS'(centre);
		row.known_res.hole_found           = found;
		return row;
	endfunction

	function automatic directed_row_t write_row(input logic [ADDR_BITS-1:0] addr,
			input logic [DATA_BITS-1:0] data);
		directed_row_t row;
		row       = '0;
		row.kind  = ROW_WRITE;
		row.addr  = addr;
		row.wdata = data;
		return row;
	endfunction

	// mostly well-formed sweeps with runs of open and blocked space, some noise
	function automatic sample_t next_scan_sample();
		sample_t s;
		int      step;
		if ($urandom_range(99) < 15) begin
			s.scan_angle    = ANGLE_BITS'($urandom());
			s.range_dist    = DIST_BITS'($urandom());
			s.sweep_reverse = ($urandom_range(3) == 0);
			return s;
		end
		if ($urandom_range(3) == 0) begin
			sweep_open = !sweep_open;
		end
		s.scan_angle = ANGLE_BITS'(sweep_angle);
		if (sweep_open && cfg_hole != '1) begin
			s.range_dist = DIST_BITS'($urandom_range(8191, int'(cfg_hole) + 1));
		end else if (sweep_open || $urandom_range(9) == 0) begin
			s.range_dist = cfg_hole;
		end else begin
			s.range_dist = DIST_BITS'($urandom_range(int'(cfg_hole), 0));
		end
		// reverse at either end of the field, now and then early
		s.sweep_reverse = (sweep_up && sweep_angle == MAX_ANGLE) ||
			(!sweep_up && sweep_angle == 0) || ($urandom_range(39) == 0);
		if (s.sweep_reverse) begin
			sweep_up = !sweep_up;
		end
		step = $urandom_range(12, 1);
		if (sweep_up) begin
			sweep_angle = (sweep_angle + step > MAX_ANGLE) ? MAX_ANGLE : sweep_angle + step;
		end else begin
			sweep_angle = (sweep_angle < step) ? 0 : sweep_angle - step;
		end
		return s;
	endfunction

	// sample transfer, expectation queued at acceptance
	task automatic send_sample(input sample_t s, input logic known, input result_t known_res);
		result_t predicted;
		if (sender_idles && $urandom_range(3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(17, 1)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (!sample_ready);
		predicted = predict_steer(s);
		steer_results_due.push_back(known ? known_res : predicted);
	endtask

	// block goes idle once every due result has come out
	task automatic drain_results();
		sample_valid <= 1'b0;
		while (steer_results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	// setup then access cycle, then the bus goes idle
	task automatic write_reg(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (addr)
			reg_addr(REG_MIN_DIST_HOLE): cfg_hole      = data[DIST_BITS-1:0];
			reg_addr(REG_DEFAULT_DIST):  cfg_default   = data[DIST_BITS-1:0];
			reg_addr(REG_MIN_WIDTH):     cfg_min_width = data[WIDTH_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// result side: random stalls, one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_results) begin
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_results = 1'b0;
				result_ready <= 1'b1;
			end else if (receiver_idles && $urandom_range(4) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(17, 1)) @(posedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (steer_results_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT) begin
					$display("unexpected result: turn %0d centre %0d found %0d",
						$signed(result.best_turn_half_deg), result.last_center_half_deg,
						result.hole_found);
				end
			end else begin
				oldest_due = steer_results_due.pop_front();
				if (oldest_due.best_turn_half_deg !== result.best_turn_half_deg ||
						oldest_due.last_center_half_deg !== result.last_center_half_deg ||
						oldest_due.hole_found !== result.hole_found) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("result mismatch: turn %0d/%0d centre %0d/%0d found %0d/%0d (exp/act)",
							$signed(oldest_due.best_turn_half_deg),
							$signed(result.best_turn_half_deg),
							oldest_due.last_center_half_deg, result.last_center_half_deg,
							oldest_due.hole_found, result.hole_found);
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int phase;
		int unsigned hole;
		int unsigned dflt;
		int unsigned min_w;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk: gap open and close on every path, reversal clear, extremes
		directed_rows = '{
			known_row(0, 0, 1'b0, 0, 0, 1'b0),
			write_row(reg_addr(REG_MIN_DIST_HOLE), 32'd1000),
			write_row(reg_addr(REG_DEFAULT_DIST), 32'd8191),
			write_row(reg_addr(REG_MIN_WIDTH), 32'd0),
			scan_row(0, 500, 1'b0),
			scan_row(1, 8191, 1'b0),
			scan_row(180, 1000, 1'b0),
			scan_row(200, 8191, 1'b0),
			scan_row(10, 999, 1'b0),
			scan_row(90, 8191, 1'b0),
			scan_row(100, 0, 1'b1),
			scan_row(255, 0, 1'b0),
			scan_row(255, 8191, 1'b0),
			known_row(255, 8191, 1'b1, 255, 510, 1'b1),
			known_row(0, 0, 1'b1, 0, 510, 1'b0),
			write_row(reg_addr(REG_MIN_WIDTH), 32'hFFFF_FFFF),
			scan_row(0, 8191, 1'b0),
			scan_row(180, 0, 1'b0),
			scan_row(90, 8191, 1'b1),
			write_row(UNUSED_REG_ADDR, 32'hFFFF_FFFF),
			write_row(reg_addr(REG_MIN_DIST_HOLE), 32'd8191),
			scan_row(170, 8191, 1'b0),
			scan_row(0, 8191, 1'b0)
		};
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				drain_results();
				write_reg(directed_rows[i].addr, directed_rows[i].wdata);
			end else begin
				send_sample(directed_rows[i].scan, directed_rows[i].known,
					directed_rows[i].known_res);
			end
		end

		// random sweeps under a range of register settings
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_results();
			case (phase)
				0: begin
					hole  = $urandom_range(3000, 300);
					dflt  = $urandom();
					min_w = $urandom_range(2000);
				end
				1: begin
					hole  = 0;
					dflt  = 8191;
					min_w = 0;
				end
				2: begin
					hole  = 8191;
					dflt  = 0;
					min_w = 16383;
				end
				3: begin
					hole  = $urandom_range(6000, 1000);
					dflt  = $urandom();
					min_w = $urandom_range(1500);
				end
				4: begin
					hole  = $urandom_range(8191);
					dflt  = $urandom();
					min_w = $urandom_range(4000);
				end
				default: begin
					hole  = $urandom_range(2500, 200);
					dflt  = $urandom();
					min_w = 280;
				end
			endcase
			write_reg(reg_addr(REG_MIN_DIST_HOLE), with_junk(hole, DIST_BITS));
			write_reg(reg_addr(REG_DEFAULT_DIST), with_junk(dflt, DIST_BITS));
			write_reg(reg_addr(REG_MIN_WIDTH), with_junk(min_w, WIDTH_BITS));
			// no idling at the tail, steady offers while the result side is held
			sender_idles   = (phase != PRESSURE_PHASE) && (phase != RANDOM_PHASES - 1);
			receiver_idles = (phase != RANDOM_PHASES - 1);
			if (phase == PRESSURE_PHASE) begin
				hold_results = 1'b1;
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_sample(next_scan_sample(), 1'b0, '0);
			end
		end

		drain_results();
		if (mismatch_count == 0 && steer_results_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
